[rtl/wcr_pkg.sv]
// Shared types and constants of the waveform column renderer.
`default_nettype none
package wcr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 6;
  localparam int PAGE_W     = 3;
  localparam int ZOOM_W     = 4;
  localparam int OFFSET_W   = 8;
  localparam int SUM_W      = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam int DISPLAY_ROWS = 64;
  localparam int FULL_SCALE   = 32767;
  localparam int FULL_SHIFT   = 9;
  localparam int HALF_SHIFT   = 10;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = 16'hffff;

  localparam logic [PAGE_W-1:0] PAGE_FULL = 3'd0;
  localparam logic [PAGE_W-1:0] PAGE_HALF = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_ZOOM   = 3'd0,
    CFG_VERT_ZOOM   = 3'd1,
    CFG_VERT_OFFSET = 3'd2,
    CFG_HALF_HEIGHT = 3'd3,
    CFG_DUAL_MODE   = 3'd4,
    CFG_LINE_STYLE  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_e;

  typedef struct packed {
    logic [COL_W-1:0]  column_x;
    logic [PAGE_W-1:0] first_cleared_page;
    logic [ROW_W-1:0]  dot_row;
    logic [ROW_W-1:0]  span_top;
    logic [ROW_W-1:0]  span_bottom;
    logic              draw_line;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/wcr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module wcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/wcr_div.sv]
// Restoring divider, one quotient bit per cycle, for sample index / time zoom.
`default_nettype none
module wcr_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [wcr_pkg::IDX_W-1:0]   dividend_i,
  input  wire logic [wcr_pkg::ZOOM_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic      [wcr_pkg::IDX_W-1:0]   quotient_o
);

  localparam int CntW = $clog2(wcr_pkg::IDX_W);
  localparam int RemW = wcr_pkg::ZOOM_W + 1;

  logic                        busy_q;
  logic                        done_q;
  logic [CntW-1:0]             cnt_q;
  logic [wcr_pkg::IDX_W-1:0]   dvd_q;
  logic [wcr_pkg::IDX_W-1:0]   quo_q;
  logic [RemW-1:0]             rem_q;
  logic [wcr_pkg::ZOOM_W-1:0]  dsr_q;

  logic [RemW-1:0] trial;
  logic            ge;

  assign trial = {rem_q[RemW-2:0], dvd_q[wcr_pkg::IDX_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(wcr_pkg::IDX_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[wcr_pkg::IDX_W-2:0], 1'b0};
      rem_q <= ge ? (trial - {1'b0, dsr_q}) : trial;
      quo_q <= {quo_q[wcr_pkg::IDX_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

[rtl/waveform_column_renderer_top.sv]
// Waveform column renderer: sample store plus a sequencer that turns columns into rows.
//
// Input stream: tuser is the operation (0 load, 1 render). A load writes one sample
// into the store; the block is ready again the next cycle.
// A render reads the column's sample and, in line style, its neighbors that lie in
// the store. Each sample read passes through the 8-step shared divider that forms
// the index / time zoom and signals done, then a RAM read and a row-mapping step.
// Columns whose sample index falls outside the store produce no result.
// Input tready is low while a render is in progress.
// Output stream: one result per in-range render, held in an output register; a new
// item is accepted while a result waits. If the receiver stalls, a finished render
// waits in its last step until the output register is free.
// Configuration writes take effect at once; the user must make them only while idle,
// and the block does not enforce this. Reset clears the configuration to its defaults
// and empties the output; the sample store is not cleared, and a column must not read
// a sample that was never loaded.
`default_nettype none
module waveform_column_renderer_top #(
  parameter int SAMPLE_COUNT = 128,
  parameter int OFFSET_STEP  = 512
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // tdata: sample_index[6:0], sample_value[22:7], column[29:23], zero fill
  input  wire logic [wcr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // tuser: operation[0]
  input  wire logic                                s_axis_tuser,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: column_x[6:0], first_cleared_page[9:7], dot_row[15:10],
  //        span_top[21:16], span_bottom[27:22], zero fill
  output logic      [wcr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: draw_line[0]
  output logic                                     m_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_we_i,
  input  wire logic [wcr_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [wcr_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int AW = $clog2(SAMPLE_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_ROW,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    PH_CENTER,
    PH_PREV,
    PH_NEXT
  } phase_e;

  // configuration
  logic [wcr_pkg::ZOOM_W-1:0]          tz_q, vz_q;
  logic signed [wcr_pkg::OFFSET_W-1:0] off_q;
  logic                                half_q, dual_q, line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tz_q   <= 4'd1;
      vz_q   <= 4'd1;
      off_q  <= '0;
      half_q <= 1'b0;
      dual_q <= 1'b0;
      line_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wcr_pkg::CFG_TIME_ZOOM:   tz_q   <= cfg_data_i[wcr_pkg::ZOOM_W-1:0];
        wcr_pkg::CFG_VERT_ZOOM:   vz_q   <= cfg_data_i[wcr_pkg::ZOOM_W-1:0];
        wcr_pkg::CFG_VERT_OFFSET: off_q  <= cfg_data_i;
        wcr_pkg::CFG_HALF_HEIGHT: half_q <= cfg_data_i[0];
        wcr_pkg::CFG_DUAL_MODE:   dual_q <= cfg_data_i[0];
        wcr_pkg::CFG_LINE_STYLE:  line_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [wcr_pkg::ZOOM_W-1:0] tz_eff, vz_eff;
  assign tz_eff = (tz_q == '0) ? wcr_pkg::ZOOM_W'(1) : tz_q;
  assign vz_eff = (vz_q == '0) ? wcr_pkg::ZOOM_W'(1) : vz_q;

  // input unpacking
  logic [wcr_pkg::COL_W-1:0]    in_sidx, in_col;
  logic [wcr_pkg::SAMPLE_W-1:0] in_sval;
  logic                         in_xfer;
  logic [wcr_pkg::IDX_W-1:0]    in_m;
  logic                         in_m_ok;

  assign in_sidx = s_axis_tdata[6:0];
  assign in_sval = s_axis_tdata[22:7];
  assign in_col  = s_axis_tdata[29:23];
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign in_m    = dual_q ? {in_col, 1'b0} : {1'b0, in_col};
  assign in_m_ok = 9'(in_m) < 9'(SAMPLE_COUNT);

  // sequencer state
  state_e                       state_q, state_d;
  phase_e                       phase_q, phase_d;
  logic [wcr_pkg::IDX_W-1:0]    m_q, m_d;
  logic [wcr_pkg::COL_W-1:0]    col_q, col_d;
  logic [wcr_pkg::ROW_W-1:0]    c_q, c_d, lo_q, lo_d, hi_q, hi_d;
  wcr_pkg::out_item_t           out_q, out_d;
  logic                         ovalid_q, ovalid_d;

  // divider and store
  logic                         div_start, div_done;
  logic [wcr_pkg::IDX_W-1:0]    div_dvd, div_quo;
  logic                         ram_we;
  logic [wcr_pkg::SAMPLE_W-1:0] ram_rdata;

  assign ram_we = in_xfer && (s_axis_tuser == wcr_pkg::OP_LOAD)
                  && (9'(in_sidx) < 9'(SAMPLE_COUNT));

  wcr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (tz_eff),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  wcr_ram #(
    .WIDTH (wcr_pkg::SAMPLE_W),
    .DEPTH (SAMPLE_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_sidx)),
    .wdata_i (in_sval),
    .re_i    (state_q == ST_READ),
    .raddr_i (AW'(div_quo)),
    .rdata_o (ram_rdata)
  );

  // sample to row
  logic [wcr_pkg::SAMPLE_W-1:0]    sat_mask, shifted, v_pre;
  logic                            sat;
  logic signed [wcr_pkg::SUM_W-1:0] off_scaled, sum;
  logic [14:0]                     v;
  logic [14:0]                     v_sh;
  logic [wcr_pkg::ROW_W-1:0]       row;

  always_comb begin
    sat_mask   = wcr_pkg::SAMPLE_MASK >> vz_eff;
    sat        = |(ram_rdata & ~sat_mask);
    shifted    = ram_rdata << (vz_eff - 1'b1);
    v_pre      = sat ? wcr_pkg::SAMPLE_W'(wcr_pkg::FULL_SCALE) : shifted;
    off_scaled = wcr_pkg::SUM_W'(off_q) * $signed(wcr_pkg::SUM_W'(OFFSET_STEP));
    sum        = $signed(wcr_pkg::SUM_W'(v_pre)) + off_scaled;
    if (sum < 0) begin
      v = '0;
    end else if (sum > $signed(wcr_pkg::SUM_W'(wcr_pkg::FULL_SCALE))) begin
      v = 15'(wcr_pkg::FULL_SCALE);
    end else begin
      v = sum[14:0];
    end
    v_sh = half_q ? (v >> wcr_pkg::HALF_SHIFT) : (v >> wcr_pkg::FULL_SHIFT);
    row  = wcr_pkg::ROW_W'(wcr_pkg::DISPLAY_ROWS - 1) - v_sh[wcr_pkg::ROW_W-1:0];
  end

  // neighbor handling
  logic [wcr_pkg::IDX_W-1:0] step;
  logic                      has_prev, has_next;
  logic [wcr_pkg::ROW_W:0]   mid_sum;
  logic [wcr_pkg::ROW_W-1:0] mid;

  assign step     = dual_q ? wcr_pkg::IDX_W'(2) : wcr_pkg::IDX_W'(1);
  assign has_prev = line_q && (m_q >= step);
  assign has_next = line_q && ((9'(m_q) + 9'(step)) < 9'(SAMPLE_COUNT));
  assign mid_sum  = {1'b0, row} + {1'b0, c_q};
  assign mid      = mid_sum[wcr_pkg::ROW_W:1];

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    m_d       = m_q;
    col_d     = col_q;
    c_d       = c_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    out_d     = out_q;
    ovalid_d  = ovalid_q;
    div_start = 1'b0;
    div_dvd   = in_m;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer && (s_axis_tuser == wcr_pkg::OP_RENDER) && in_m_ok) begin
          m_d       = in_m;
          col_d     = in_col;
          phase_d   = PH_CENTER;
          div_start = 1'b1;
          div_dvd   = in_m;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_ROW;
      end
      ST_ROW: begin
        if (phase_q == PH_CENTER) begin
          c_d  = row;
          lo_d = row;
          hi_d = row;
        end else begin
          if ((row < c_q) && (mid < lo_q)) begin
            lo_d = mid;
          end
          if ((row > c_q) && (mid > hi_q)) begin
            hi_d = mid;
          end
        end
        if ((phase_q == PH_CENTER) && has_prev) begin
          phase_d   = PH_PREV;
          div_start = 1'b1;
          div_dvd   = m_q - step;
          state_d   = ST_DIV;
        end else if ((phase_q != PH_NEXT) && has_next) begin
          phase_d   = PH_NEXT;
          div_start = 1'b1;
          div_dvd   = m_q + step;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!ovalid_q || m_axis_tready) begin
          out_d.column_x           = col_q;
          out_d.first_cleared_page = half_q ? wcr_pkg::PAGE_HALF : wcr_pkg::PAGE_FULL;
          out_d.dot_row            = c_q;
          out_d.span_top           = lo_q;
          out_d.span_bottom        = hi_q;
          out_d.draw_line          = line_q;
          ovalid_d                 = 1'b1;
          state_d                  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= PH_CENTER;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    col_q <= col_d;
    c_q   <= c_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    out_q <= out_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = out_q.draw_line;
  assign m_axis_tdata  = {4'b0000, out_q.span_bottom, out_q.span_top, out_q.dot_row,
                          out_q.first_cleared_page, out_q.column_x};

endmodule
`default_nettype wire

[rtl/wcr_checker.sv]
// Port-level checks of the waveform column renderer, bound to the top level.
`default_nettype none
module wcr_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [wcr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                           m_axis_tuser
);

  logic [wcr_pkg::ROW_W-1:0] dot, top, bot;
  assign dot = m_axis_tdata[15:10];
  assign top = m_axis_tdata[21:16];
  assign bot = m_axis_tdata[27:22];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == wcr_pkg::OP_LOAD) |=> s_axis_tready)
    else $error("load transfer stalled the input");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result issued while a render is still busy");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (top <= dot) && (dot <= bot) && (m_axis_tdata[31:28] == 4'b0000)
      && ((m_axis_tdata[9:7] == wcr_pkg::PAGE_FULL)
          || (m_axis_tdata[9:7] == wcr_pkg::PAGE_HALF)))
    else $error("malformed result");

endmodule

bind waveform_column_renderer_top wcr_checker u_wcr_checker (.*);
`default_nettype wire
